// ===== src/bpor_pkg.sv =====
package bpor_pkg;

   // integer bits of the ratio result
   localparam int INT_BITS = 3;

   // entries held between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // back-end sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_SAT  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } back_state_type;

   // steps of the shared multiplier
   typedef enum logic [2:0] {
      MS_OV_XY = 3'd0,
      MS_OV_Z  = 3'd1,
      MS_B1_XY = 3'd2,
      MS_B1_Z  = 3'd3,
      MS_B2_XY = 3'd4,
      MS_B2_Z  = 3'd5
   } mul_step_type;

endpackage

// ===== src/box_pair_overlap_ratio_top.sv =====
// Box pair overlap ratio. A word with req_second_box low stores its box,
// subject and time interval and gives no result; a word with req_second_box
// high is compared with the stored box and gives one result: pair_matches
// when the subjects differ and the boxes overlap in time and on all three
// axes, and overlap_ratio, twice the overlap volume over the summed volume
// terms, unsigned Q3.FRAC_BITS, saturating, zero when there is no match.
// The front takes a word every cycle while its two-entry queue has room.
// The back handles one compare at a time: a non-matching pair goes straight
// to the result register, a matching pair passes through six steps of one
// shared multiplier, a saturation check and, unless the ratio saturates, a
// restoring divider that yields one quotient bit per cycle.
module box_pair_overlap_ratio_top #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_second_box,
   input  logic [15:0]                              req_subject_id,
   input  logic [COORD_BITS-1:0]                    req_min_x,
   input  logic [COORD_BITS-1:0]                    req_min_y,
   input  logic [COORD_BITS-1:0]                    req_min_z,
   input  logic [COORD_BITS-1:0]                    req_max_x,
   input  logic [COORD_BITS-1:0]                    req_max_y,
   input  logic [COORD_BITS-1:0]                    req_max_z,
   input  logic [15:0]                              req_time_low,
   input  logic [15:0]                              req_time_high,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_pair_matches,
   output logic [bpor_pkg::INT_BITS+FRAC_BITS-1:0]  rsp_overlap_ratio
);

   localparam int EW = 9 * COORD_BITS + 4;

   logic          push_valid;
   logic          push_ready;
   logic [EW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [EW-1:0] pop_data;

   // classify and hold boxes
   bpor_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_second_box (req_second_box),
      .req_subject_id (req_subject_id),
      .req_min_x      (req_min_x),
      .req_min_y      (req_min_y),
      .req_min_z      (req_min_z),
      .req_max_x      (req_max_x),
      .req_max_y      (req_max_y),
      .req_max_z      (req_max_z),
      .req_time_low   (req_time_low),
      .req_time_high  (req_time_high),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // compare words waiting for the back
   bpor_queue #(
      .WIDTH (EW),
      .DEPTH (bpor_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // volumes, ratio and result register
   bpor_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pair_matches  (rsp_pair_matches),
      .rsp_overlap_ratio (rsp_overlap_ratio)
   );

endmodule

// ===== src/bpor_front.sv =====
module bpor_front #(
   parameter int COORD_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_second_box,
   input  logic [15:0]               req_subject_id,
   input  logic [COORD_BITS-1:0]     req_min_x,
   input  logic [COORD_BITS-1:0]     req_min_y,
   input  logic [COORD_BITS-1:0]     req_min_z,
   input  logic [COORD_BITS-1:0]     req_max_x,
   input  logic [COORD_BITS-1:0]     req_max_y,
   input  logic [COORD_BITS-1:0]     req_max_z,
   input  logic [15:0]               req_time_low,
   input  logic [15:0]               req_time_high,
   output logic                      push_valid,
   input  logic                      push_ready,
   output logic [9*COORD_BITS+3:0]   push_data
);

   localparam int OVW = COORD_BITS + 1;

   logic [15:0]           held_subject_ff, held_subject_in;
   logic [COORD_BITS-1:0] held_min_ff [3];
   logic [COORD_BITS-1:0] held_min_in [3];
   logic [COORD_BITS-1:0] held_max_ff [3];
   logic [COORD_BITS-1:0] held_max_in [3];
   logic [15:0]           held_tlo_ff, held_tlo_in;
   logic [15:0]           held_thi_ff, held_thi_in;

   logic [COORD_BITS-1:0] cur_min [3];
   logic [COORD_BITS-1:0] cur_max [3];
   logic [COORD_BITS-1:0] top [3];
   logic [COORD_BITS-1:0] bot [3];
   logic [OVW-1:0]        ov [3];
   logic [COORD_BITS-1:0] d_held [3];
   logic [COORD_BITS-1:0] d_cur [3];
   logic [2:0]            axis_ok;
   logic                  time_ok;
   logic                  match;
   logic                  store;

   assign cur_min[0] = req_min_x;
   assign cur_min[1] = req_min_y;
   assign cur_min[2] = req_min_z;
   assign cur_max[0] = req_max_x;
   assign cur_max[1] = req_max_y;
   assign cur_max[2] = req_max_z;

   // words are taken whenever the queue has room
   assign req_ready  = push_ready;
   assign push_valid = req_valid & req_second_box;
   assign store      = req_valid & req_ready & ~req_second_box;

   // per-axis overlap and box extents
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         top[a]     = (held_max_ff[a] < cur_max[a]) ? held_max_ff[a] : cur_max[a];
         bot[a]     = (held_min_ff[a] > cur_min[a]) ? held_min_ff[a] : cur_min[a];
         axis_ok[a] = (top[a] >= bot[a]);
         ov[a]      = axis_ok[a] ? (OVW'(top[a]) - OVW'(bot[a]) + OVW'(1)) : '0;
         d_held[a]  = held_max_ff[a] - held_min_ff[a];
         d_cur[a]   = cur_max[a] - cur_min[a];
      end
   end

   // subject, time and space tests
   assign time_ok = ~(req_time_low > held_thi_ff) & ~(held_tlo_ff > req_time_high);
   assign match   = (req_subject_id != held_subject_ff) & time_ok & (&axis_ok);

   assign push_data = {match, ov[0], ov[1], ov[2],
                       d_held[0], d_held[1], d_held[2],
                       d_cur[0], d_cur[1], d_cur[2]};

   // held box update on a store word
   always_comb begin
      held_subject_in = held_subject_ff;
      held_tlo_in     = held_tlo_ff;
      held_thi_in     = held_thi_ff;
      held_min_in     = held_min_ff;
      held_max_in     = held_max_ff;
      if (store) begin
         held_subject_in = req_subject_id;
         held_tlo_in     = req_time_low;
         held_thi_in     = req_time_high;
         held_min_in     = cur_min;
         held_max_in     = cur_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_subject_ff <= '0;
         held_tlo_ff     <= '0;
         held_thi_ff     <= '0;
         for (int a = 0; a < 3; a++) begin
            held_min_ff[a] <= '0;
            held_max_ff[a] <= '0;
         end
      end else begin
         held_subject_ff <= held_subject_in;
         held_tlo_ff     <= held_tlo_in;
         held_thi_ff     <= held_thi_in;
         held_min_ff     <= held_min_in;
         held_max_ff     <= held_max_in;
      end
   end

endmodule

// ===== src/bpor_queue.sv =====
module bpor_queue #(
   parameter int WIDTH = 94,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (cnt_ff != CNTW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + CNTW'(1);
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/bpor_back.sv =====
module bpor_back #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     pop_valid,
   output logic                                     pop_ready,
   input  logic [9*COORD_BITS+3:0]                  pop_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_pair_matches,
   output logic [bpor_pkg::INT_BITS+FRAC_BITS-1:0]  rsp_overlap_ratio
);

   localparam int OVW  = COORD_BITS + 1;
   localparam int AW   = 2 * COORD_BITS + 2;
   localparam int PW   = 3 * COORD_BITS + 3;
   localparam int DVW  = PW + 3;
   localparam int RW   = PW + 4;
   localparam int QW   = bpor_pkg::INT_BITS + FRAC_BITS;
   localparam int CNTW = $clog2(QW);

   bpor_pkg::back_state_type state_ff, state_in;
   bpor_pkg::mul_step_type   step_ff, step_in;

   logic                  match_ff, match_in;
   logic [OVW-1:0]        ov_ff [3];
   logic [OVW-1:0]        ov_in [3];
   logic [COORD_BITS-1:0] d1_ff [3];
   logic [COORD_BITS-1:0] d1_in [3];
   logic [COORD_BITS-1:0] d2_ff [3];
   logic [COORD_BITS-1:0] d2_in [3];
   logic [PW-1:0]         pa_ff, pa_in;
   logic [PW-1:0]         pb_ff, pb_in;
   logic [PW-1:0]         pc_ff, pc_in;
   logic [RW-1:0]         r_ff, r_in;
   logic [DVW-1:0]        dv_ff, dv_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_match_ff, rsp_match_in;
   logic [QW-1:0]         rsp_ratio_ff, rsp_ratio_in;

   logic                  e_match;
   logic [OVW-1:0]        e_ov [3];
   logic [COORD_BITS-1:0] e_d1 [3];
   logic [COORD_BITS-1:0] e_d2 [3];
   logic [AW-1:0]         mul_a;
   logic [OVW-1:0]        mul_b;
   logic [PW-1:0]         mul_p;
   logic [PW:0]           den;
   logic [RW-1:0]         num_ext;
   logic [RW-1:0]         den8;
   logic                  sat;
   logic                  ge;
   logic [RW-1:0]         r_sel;
   logic                  load_out;

   assign {e_match, e_ov[0], e_ov[1], e_ov[2],
           e_d1[0], e_d1[1], e_d1[2],
           e_d2[0], e_d2[1], e_d2[2]} = pop_data;

   assign pop_ready = (state_ff == bpor_pkg::ST_IDLE);

   // shared multiplier operand select
   always_comb begin
      case (step_ff)
         bpor_pkg::MS_OV_XY: begin
            mul_a = AW'(ov_ff[0]);
            mul_b = ov_ff[1];
         end
         bpor_pkg::MS_OV_Z: begin
            mul_a = pa_ff[AW-1:0];
            mul_b = ov_ff[2];
         end
         bpor_pkg::MS_B1_XY: begin
            mul_a = AW'(d1_ff[0]);
            mul_b = OVW'(d1_ff[1]);
         end
         bpor_pkg::MS_B1_Z: begin
            mul_a = pb_ff[AW-1:0];
            mul_b = OVW'(d1_ff[2]);
         end
         bpor_pkg::MS_B2_XY: begin
            mul_a = AW'(d2_ff[0]);
            mul_b = OVW'(d2_ff[1]);
         end
         bpor_pkg::MS_B2_Z: begin
            mul_a = pc_ff[AW-1:0];
            mul_b = OVW'(d2_ff[2]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // summed volume terms and the saturation test
   assign den     = {1'b0, pb_ff} + {1'b0, pc_ff} + (PW+1)'(2);
   assign num_ext = RW'({pa_ff, 1'b0});
   assign den8    = {den, 3'b000};
   assign sat     = (num_ext >= den8);

   // restoring divide step against four times the divisor
   assign ge    = (r_ff >= RW'(dv_ff));
   assign r_sel = ge ? (r_ff - RW'(dv_ff)) : r_ff;

   assign load_out = (state_ff == bpor_pkg::ST_DONE) & (~rsp_valid_ff | rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      match_in = match_ff;
      ov_in    = ov_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      pc_in    = pc_ff;
      r_in     = r_ff;
      dv_in    = dv_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         bpor_pkg::ST_IDLE: begin
            if (pop_valid) begin
               match_in = e_match;
               ov_in    = e_ov;
               d1_in    = e_d1;
               d2_in    = e_d2;
               quo_in   = '0;
               step_in  = bpor_pkg::MS_OV_XY;
               state_in = e_match ? bpor_pkg::ST_MUL : bpor_pkg::ST_DONE;
            end
         end
         bpor_pkg::ST_MUL: begin
            case (step_ff)
               bpor_pkg::MS_OV_XY, bpor_pkg::MS_OV_Z: pa_in = mul_p;
               bpor_pkg::MS_B1_XY, bpor_pkg::MS_B1_Z: pb_in = mul_p;
               default:                               pc_in = mul_p;
            endcase
            if (step_ff == bpor_pkg::MS_B2_Z) begin
               state_in = bpor_pkg::ST_SAT;
            end else begin
               step_in = bpor_pkg::mul_step_type'(step_ff + 3'd1);
            end
         end
         bpor_pkg::ST_SAT: begin
            if (sat) begin
               quo_in   = '1;
               state_in = bpor_pkg::ST_DONE;
            end else begin
               r_in     = num_ext;
               dv_in    = {den, 2'b00};
               cnt_in   = '0;
               state_in = bpor_pkg::ST_DIV;
            end
         end
         bpor_pkg::ST_DIV: begin
            r_in   = {r_sel[RW-2:0], 1'b0};
            quo_in = {quo_ff[QW-2:0], ge};
            if (cnt_ff == CNTW'(QW - 1)) begin
               state_in = bpor_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         bpor_pkg::ST_DONE: begin
            if (load_out) begin
               state_in = bpor_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpor_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      rsp_ratio_in = rsp_ratio_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = match_ff;
         rsp_ratio_in = quo_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpor_pkg::ST_IDLE;
         step_ff      <= bpor_pkg::MS_OV_XY;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      match_ff     <= match_in;
      ov_ff        <= ov_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      r_ff         <= r_in;
      dv_ff        <= dv_in;
      quo_ff       <= quo_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ratio_ff <= rsp_ratio_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_matches  = rsp_match_ff;
   assign rsp_overlap_ratio = rsp_ratio_ff;

endmodule

// ===== src/bpor_checker.sv =====
module bpor_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     req_second_box,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic                                     rsp_pair_matches,
   input logic [bpor_pkg::INT_BITS+FRAC_BITS-1:0]  rsp_overlap_ratio
);

   logic [3:0] pend_ff, pend_in;
   logic       cmp_word;
   logic       rsp_word;

   // compare words accepted and not yet answered
   assign cmp_word = req_valid & req_ready & req_second_box;
   assign rsp_word = rsp_valid & rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (cmp_word & ~rsp_word) begin
         pend_in = pend_ff + 4'd1;
      end else if (rsp_word & ~cmp_word) begin
         pend_in = pend_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_matches)
                                  && $stable(rsp_overlap_ratio))
      else $error("result changed while stalled");

   // no ratio without a match
   a_ratio_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pair_matches |-> rsp_overlap_ratio == '0)
      else $error("nonzero ratio on unmatched pair");

   // reset empties the output
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every result answers an earlier compare word
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result without a pending compare word");

endmodule

bind box_pair_overlap_ratio_top bpor_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_bpor_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_second_box    (req_second_box),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pair_matches  (rsp_pair_matches),
   .rsp_overlap_ratio (rsp_overlap_ratio)
);

// ===== dv/box_pair_overlap_ratio_top_tb.sv =====
`timescale 1ns / 100ps

module box_pair_overlap_ratio_top_tb;

   localparam int COORD_BITS    = 10;
   localparam int FRAC_BITS     = 16;
   localparam int RATIO_W       = bpor_pkg::INT_BITS + FRAC_BITS;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SEG_WORDS     = 112;
   localparam int TAIL_CYCLES   = 60;
   localparam int COORD_TOP     = (1 << COORD_BITS) - 1;

   // idle pattern that applies while a word is in flight
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic                  drain_first;
      idle_mode_type         idle_mode;
      logic                  second_box;
      logic [15:0]           subject_id;
      logic [COORD_BITS-1:0] min_x;
      logic [COORD_BITS-1:0] min_y;
      logic [COORD_BITS-1:0] min_z;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] max_y;
      logic [COORD_BITS-1:0] max_z;
      logic [15:0]           time_low;
      logic [15:0]           time_high;
   } box_word_type;

   typedef struct packed {
      logic               pair_matches;
      logic [RATIO_W-1:0] overlap_ratio;
   } pair_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_second_box = 1'b0;
   logic [15:0]           req_subject_id = '0;
   logic [COORD_BITS-1:0] req_min_x = '0;
   logic [COORD_BITS-1:0] req_min_y = '0;
   logic [COORD_BITS-1:0] req_min_z = '0;
   logic [COORD_BITS-1:0] req_max_x = '0;
   logic [COORD_BITS-1:0] req_max_y = '0;
   logic [COORD_BITS-1:0] req_max_z = '0;
   logic [15:0]           req_time_low = '0;
   logic [15:0]           req_time_high = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_pair_matches;
   logic [RATIO_W-1:0]    rsp_overlap_ratio;

   box_word_type    pending_words[$];
   pair_result_type pair_results_exp[$];
   box_word_type    gen_held;
   idle_mode_type   gen_mode;
   logic            gen_drain;
   box_word_type    cur_word = '0;
   box_word_type    held_box = '0;
   idle_mode_type   run_mode = IDLE_NONE;
   int              words_accepted = 0;
   int              hold_at = 32'h7fffffff;
   int              hold_left = 0;
   logic            hold_armed = 1'b1;
   int              cycle_count = 0;
   int              error_count = 0;
   int              stores_sent = 0;
   int              compares_sent = 0;
   int              results_seen = 0;
   int              matches_seen = 0;
   int              saturated_seen = 0;

   box_pair_overlap_ratio_top #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_second_box   (req_second_box),
      .req_subject_id   (req_subject_id),
      .req_min_x        (req_min_x),
      .req_min_y        (req_min_y),
      .req_min_z        (req_min_z),
      .req_max_x        (req_max_x),
      .req_max_y        (req_max_y),
      .req_max_z        (req_max_z),
      .req_time_low     (req_time_low),
      .req_time_high    (req_time_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pair_matches (rsp_pair_matches),
      .rsp_overlap_ratio(rsp_overlap_ratio)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // overlap length on one axis, zero when the spans are disjoint
   function automatic logic [COORD_BITS:0] axis_overlap_len(
      input logic [COORD_BITS-1:0] lo_a, input logic [COORD_BITS-1:0] hi_a,
      input logic [COORD_BITS-1:0] lo_b, input logic [COORD_BITS-1:0] hi_b);
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] bot;
      top = (hi_a < hi_b) ? hi_a : hi_b;
      bot = (lo_a > lo_b) ? lo_a : lo_b;
      if (top < bot) return '0;
      return {1'b0, top} - {1'b0, bot} + 1'b1;
   endfunction

   // dx*dy*dz + 1 of one box; inverted boxes never reach the division
   function automatic logic [63:0] volume_term(input box_word_type b);
      logic [63:0] vol;
      if (b.max_x < b.min_x || b.max_y < b.min_y || b.max_z < b.min_z) return 64'd1;
      vol = 64'(b.max_x - b.min_x) * 64'(b.max_y - b.min_y) * 64'(b.max_z - b.min_z);
      return vol + 64'd1;
   endfunction

   // expected match flag and Q3.16 ratio of a compare word against the held box
   function automatic pair_result_type predict_pair(input box_word_type held,
                                                    input box_word_type cur);
      pair_result_type res;
      logic [COORD_BITS:0] ox;
      logic [COORD_BITS:0] oy;
      logic [COORD_BITS:0] oz;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quot;
      res = '0;
      ox = axis_overlap_len(held.min_x, held.max_x, cur.min_x, cur.max_x);
      oy = axis_overlap_len(held.min_y, held.max_y, cur.min_y, cur.max_y);
      oz = axis_overlap_len(held.min_z, held.max_z, cur.min_z, cur.max_z);
      res.pair_matches = (cur.subject_id != held.subject_id)
                         && !(cur.time_low > held.time_high)
                         && !(held.time_low > cur.time_high)
                         && (ox != 0) && (oy != 0) && (oz != 0);
      if (res.pair_matches) begin
         num  = 64'd2 * 64'(ox) * 64'(oy) * 64'(oz);
         den  = volume_term(held) + volume_term(cur);
         quot = num / den;
         if (quot >= (64'd1 << bpor_pkg::INT_BITS)) begin
            res.overlap_ratio = '1;
         end else begin
            res.overlap_ratio = RATIO_W'((num << FRAC_BITS) / den);
         end
      end
      return res;
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   // queue a word, tagging it with the current idle pattern
   task automatic queue_word(input box_word_type w);
      w.idle_mode   = gen_mode;
      w.drain_first = gen_drain;
      gen_drain     = 1'b0;
      if (!w.second_box) gen_held = w;
      pending_words = {pending_words, w};
   endtask

   function automatic box_word_type make_word(
      input logic second, input logic [15:0] subj,
      input int mnx, input int mny, input int mnz,
      input int mxx, input int mxy, input int mxz,
      input logic [15:0] tlo, input logic [15:0] thi);
      box_word_type w;
      w            = '0;
      w.second_box = second;
      w.subject_id = subj;
      w.min_x      = COORD_BITS'(mnx);
      w.min_y      = COORD_BITS'(mny);
      w.min_z      = COORD_BITS'(mnz);
      w.max_x      = COORD_BITS'(mxx);
      w.max_y      = COORD_BITS'(mxy);
      w.max_z      = COORD_BITS'(mxz);
      w.time_low   = tlo;
      w.time_high  = thi;
      return w;
   endfunction

   // mostly small spans, some flat, a few up to the full range
   task automatic random_span(output logic [COORD_BITS-1:0] lo,
                              output logic [COORD_BITS-1:0] hi);
      int r;
      int size;
      int base;
      r = $urandom_range(99);
      if (r < 10) size = 0;
      else if (r < 75) size = $urandom_range(7, 1);
      else if (r < 95) size = $urandom_range(120);
      else size = $urandom_range(COORD_TOP);
      base = $urandom_range(COORD_TOP - size, 0);
      lo = COORD_BITS'(base);
      hi = COORD_BITS'(base + size);
   endtask

   // span around the held one, usually overlapping it
   task automatic near_span(input logic [COORD_BITS-1:0] anchor_lo,
                            input logic [COORD_BITS-1:0] anchor_hi,
                            output logic [COORD_BITS-1:0] lo,
                            output logic [COORD_BITS-1:0] hi);
      int a;
      int b;
      int lo_i;
      a = int'(anchor_lo) - 4;
      if (a < 0) a = 0;
      b = int'(anchor_hi);
      if (b < a) b = a;
      lo_i = $urandom_range(b, a);
      b = int'(anchor_hi) + 4;
      if (b > COORD_TOP) b = COORD_TOP;
      if (b < lo_i) b = lo_i;
      lo = COORD_BITS'(lo_i);
      hi = COORD_BITS'($urandom_range(b, lo_i));
   endtask

   // fully random word, inverted boxes and intervals included
   task automatic random_noise();
      box_word_type w;
      w            = '0;
      w.second_box = 1'($urandom_range(1));
      w.subject_id = 16'($urandom_range(16'hffff));
      w.min_x      = COORD_BITS'($urandom_range(COORD_TOP));
      w.min_y      = COORD_BITS'($urandom_range(COORD_TOP));
      w.min_z      = COORD_BITS'($urandom_range(COORD_TOP));
      w.max_x      = COORD_BITS'($urandom_range(COORD_TOP));
      w.max_y      = COORD_BITS'($urandom_range(COORD_TOP));
      w.max_z      = COORD_BITS'($urandom_range(COORD_TOP));
      w.time_low   = 16'($urandom_range(16'hffff));
      w.time_high  = 16'($urandom_range(16'hffff));
      queue_word(w);
   endtask

   // one store followed by a few compares against it
   task automatic random_group();
      box_word_type w;
      int n;
      int tlo;
      int floor_t;
      w            = '0;
      w.subject_id = 16'($urandom_range(16'hffff));
      random_span(w.min_x, w.max_x);
      random_span(w.min_y, w.max_y);
      random_span(w.min_z, w.max_z);
      tlo          = $urandom_range(16'hffff);
      w.time_low   = 16'(tlo);
      w.time_high  = 16'($urandom_range(16'hffff, tlo));
      queue_word(w);
      n = $urandom_range(4, 1);
      repeat (n) begin
         w            = '0;
         w.second_box = 1'b1;
         if ($urandom_range(9) == 0) w.subject_id = gen_held.subject_id;
         else w.subject_id = gen_held.subject_id ^ 16'($urandom_range(16'hffff, 1));
         if ($urandom_range(6) == 0) begin
            w.min_x = gen_held.min_x;
            w.min_y = gen_held.min_y;
            w.min_z = gen_held.min_z;
            w.max_x = gen_held.max_x;
            w.max_y = gen_held.max_y;
            w.max_z = gen_held.max_z;
         end else begin
            near_span(gen_held.min_x, gen_held.max_x, w.min_x, w.max_x);
            near_span(gen_held.min_y, gen_held.max_y, w.min_y, w.max_y);
            near_span(gen_held.min_z, gen_held.max_z, w.min_z, w.max_z);
         end
         if ($urandom_range(9) != 0) begin
            tlo         = $urandom_range(gen_held.time_high, 0);
            floor_t     = (tlo > gen_held.time_low) ? tlo : gen_held.time_low;
            w.time_low  = 16'(tlo);
            w.time_high = 16'($urandom_range(16'hffff, floor_t));
         end else begin
            w.time_low  = 16'($urandom_range(16'hffff));
            w.time_high = 16'($urandom_range(16'hffff));
         end
         queue_word(w);
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      box_word_type nxt;
      logic         go;
      int           pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            words_accepted <= words_accepted + 1;
            if (cur_word.second_box) begin
               pair_results_exp = {pair_results_exp, predict_pair(held_box, cur_word)};
               compares_sent++;
            end else begin
               held_box = cur_word;
               stores_sent++;
            end
         end
         if (!req_valid || req_ready) begin
            go = 1'b0;
            if (pending_words.size() != 0) begin
               nxt = pending_words[0];
               pct = (nxt.idle_mode == IDLE_SEND) ? 46 : (nxt.idle_mode == IDLE_BOTH) ? 34 : 0;
               go  = 1'b1;
               if (nxt.drain_first && pair_results_exp.size() != 0) go = 1'b0;
               else if (hold_left == 0 && $urandom_range(99) < pct) go = 1'b0;
            end
            if (go) begin
               void'(pending_words.pop_front());
               cur_word       = nxt;
               run_mode      <= nxt.idle_mode;
               req_second_box <= nxt.second_box;
               req_subject_id <= nxt.subject_id;
               req_min_x      <= nxt.min_x;
               req_min_y      <= nxt.min_y;
               req_min_z      <= nxt.min_z;
               req_max_x      <= nxt.max_x;
               req_max_y      <= nxt.max_y;
               req_max_z      <= nxt.max_z;
               req_time_low   <= nxt.time_low;
               req_time_high  <= nxt.time_high;
            end
            req_valid <= go;
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && words_accepted >= hold_at) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : watch_proc
      pair_result_type want;
      int              pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pair_results_exp.size() == 0) begin
               log_error($sformatf("unexpected result: match %0b ratio %0d",
                                   rsp_pair_matches, rsp_overlap_ratio));
            end else begin
               want = pair_results_exp.pop_front();
               if (want.pair_matches) matches_seen++;
               if (want.overlap_ratio == '1) saturated_seen++;
               if (rsp_pair_matches !== want.pair_matches
                   || rsp_overlap_ratio !== want.overlap_ratio) begin
                  log_error($sformatf(
                     "result %0d: expected match %0b ratio %0d, got match %0b ratio %0d",
                     results_seen, want.pair_matches, want.overlap_ratio,
                     rsp_pair_matches, rsp_overlap_ratio));
               end
            end
         end
         pct = (run_mode == IDLE_RECV) ? 46 : (run_mode == IDLE_BOTH) ? 34 : 0;
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin : main_proc
      int seg;
      int target;
      gen_mode  = IDLE_NONE;
      gen_drain = 1'b0;
      gen_held  = '0;

      // compare before any store, against the reset box
      queue_word(make_word(1'b1, 16'h0005, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000));
      queue_word(make_word(1'b1, 16'h0000, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000));
      // full-range box, same and different subjects, corner voxel, inverted axis
      queue_word(make_word(1'b0, 16'hffff, 0, 0, 0, COORD_TOP, COORD_TOP, COORD_TOP,
                           16'h0000, 16'hffff));
      queue_word(make_word(1'b1, 16'hffff, 0, 0, 0, COORD_TOP, COORD_TOP, COORD_TOP,
                           16'h0000, 16'hffff));
      queue_word(make_word(1'b1, 16'h0000, 0, 0, 0, COORD_TOP, COORD_TOP, COORD_TOP,
                           16'hffff, 16'hffff));
      queue_word(make_word(1'b1, 16'h1234, COORD_TOP, COORD_TOP, COORD_TOP,
                           COORD_TOP, COORD_TOP, COORD_TOP, 16'h0000, 16'h0000));
      queue_word(make_word(1'b1, 16'h0001, 10, 5, 0, 5, 20, 20, 16'h0000, 16'h0100));
      // flat boxes drive the ratio into saturation; time edges around them
      queue_word(make_word(1'b0, 16'haaaa, 0, 0, 0, 0, COORD_TOP, COORD_TOP,
                           16'h0100, 16'h0200));
      queue_word(make_word(1'b1, 16'h5555, 0, 0, 0, 0, COORD_TOP, COORD_TOP,
                           16'h0200, 16'h0300));
      queue_word(make_word(1'b1, 16'h5555, 0, 0, 0, 0, COORD_TOP, COORD_TOP,
                           16'h0201, 16'hffff));
      queue_word(make_word(1'b1, 16'h5555, 0, 0, 0, 0, COORD_TOP, COORD_TOP,
                           16'h0000, 16'h00ff));
      // inverted held time interval
      queue_word(make_word(1'b0, 16'h0007, 100, 100, 100, 101, 101, 101, 16'h0500, 16'h0400));
      queue_word(make_word(1'b1, 16'h0008, 100, 100, 100, 101, 101, 101, 16'h0450, 16'h0460));
      queue_word(make_word(1'b1, 16'h0008, 100, 100, 100, 101, 101, 101, 16'h0300, 16'h0480));
      queue_word(make_word(1'b1, 16'h0008, 100, 100, 100, 101, 101, 101, 16'h0400, 16'h0500));
      // single voxel box, touching and disjoint neighbors
      queue_word(make_word(1'b0, 16'h0009, 500, 500, 500, 500, 500, 500, 16'h0000, 16'h0010));
      queue_word(make_word(1'b1, 16'h000a, 500, 500, 500, 500, 500, 500, 16'h0010, 16'h0020));
      queue_word(make_word(1'b1, 16'h000a, 500, 500, 500, 600, 600, 600, 16'h0005, 16'h0005));
      queue_word(make_word(1'b1, 16'h000a, 501, 500, 500, 600, 600, 600, 16'h0000, 16'h0010));

      // random segments, each starting after the block has drained
      for (seg = 0; seg < 8; seg++) begin
         gen_mode  = idle_mode_type'(seg % 4);
         gen_drain = 1'b1;
         target    = pending_words.size() + SEG_WORDS;
         if (seg == 4) hold_at = pending_words.size() + 30;
         while (pending_words.size() < target) begin
            if ($urandom_range(99) < 85) random_group();
            else random_noise();
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || pair_results_exp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pair_results_exp.size() != 0)
         log_error($sformatf("%0d expected results never arrived", pair_results_exp.size()));

      $display("covered %0d stores and %0d compares: %0d matching pairs, %0d saturated ratios",
               stores_sent, compares_sent, matches_seen, saturated_seen);
      $display("idle patterns: none, sender, receiver, both; one long receiver hold-off");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bpor_pkg.sv
src/bpor_front.sv
src/bpor_queue.sv
src/bpor_back.sv
src/box_pair_overlap_ratio_top.sv
src/bpor_checker.sv
dv/box_pair_overlap_ratio_top_tb.sv
